// File: design/grid_min_cost_path_defines.svh
// Assertion macros shared by the grid minimum cost path checkers.
// Each macro expects clk and rst in the scope where it is used.
`ifndef GRID_MIN_COST_PATH_DEFINES_SVH
`define GRID_MIN_COST_PATH_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define GMCP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define GMCP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/gmcp_pkg.sv
// Shared constants and types for the grid minimum cost path block.
// No dependencies.
package gmcp_pkg;

  localparam int MAX_COLS_DEF    = 1024;
  localparam int MAX_ROWS_DEF    = 1024;
  localparam int COST_WIDTH_DEF  = 16;
  localparam int OUT_WIDTH       = 27;
  localparam int CFG_DATA_WIDTH  = 11;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROW_COUNT = CFG_INDEX_WIDTH'(0);
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_COL_COUNT = CFG_INDEX_WIDTH'(1);

  typedef struct packed {
    logic first_row;
    logic first_col;
    logic last;
  } cell_flags_t;

endpackage

// File: design/grid_min_cost_path.sv
// Grid minimum cost path. Cell costs enter in row-major order, one request per clock,
// unless stalled, and each is added to the least of the partial sums above, to the left
// and above-left (first row and first column use their one neighbor). A one-row buffer
// RAM of MAX_COLS sums is read one column ahead, so the block sustains one cell per
// cycle unless stalled; the result register takes min_cost from the bottom-right sum,
// and the grid restarts. A two-entry queue separates the position tracker from the sum
// datapath, so cell_stall rises only while a finished result waits under result_stall.
// Writing row_count or col_count (counts of 0 act as 1, counts above the maximum act as
// it) restarts the grid; write them only while no grid is in flight. No clearing pass.
// Depends on gmcp_pkg, gmcp_front, gmcp_queue, gmcp_back and gmcp_ram.
module grid_min_cost_path #(
  parameter int MAX_COLS   = gmcp_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS   = gmcp_pkg::MAX_ROWS_DEF,
  parameter int COST_WIDTH = gmcp_pkg::COST_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [gmcp_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [gmcp_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
  input  logic                                  cell_valid,
  output logic                                  cell_stall,
  input  logic signed [COST_WIDTH-1:0]          cell_cost,
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output logic signed [gmcp_pkg::OUT_WIDTH-1:0] min_cost
);
  import gmcp_pkg::*;

  localparam int CW        = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int SUM_WIDTH = COST_WIDTH + $clog2(MAX_ROWS + MAX_COLS) + 1;
  localparam int QW        = COST_WIDTH + CW + $bits(cell_flags_t);

  logic                         q_push;
  logic                         q_full;
  logic                         q_pop;
  logic                         q_valid;
  logic signed [COST_WIDTH-1:0] f_cost;
  logic [CW-1:0]                f_col;
  cell_flags_t                  f_flags;
  logic signed [COST_WIDTH-1:0] b_cost;
  logic [CW-1:0]                b_col;
  cell_flags_t                  b_flags;
  logic [QW-1:0]                q_wdata;
  logic [QW-1:0]                q_rdata;

  assign q_wdata = {f_cost, f_col, f_flags};
  assign {b_cost, b_col, b_flags} = q_rdata;

  gmcp_front #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_COLS  (MAX_COLS),
    .COST_WIDTH(COST_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cell_valid(cell_valid),
    .cell_stall(cell_stall),
    .cell_cost (cell_cost),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cost    (f_cost),
    .q_col     (f_col),
    .q_flags   (f_flags)
  );

  gmcp_queue #(
    .WIDTH(QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_wdata),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_valid),
    .pop_data (q_rdata)
  );

  gmcp_back #(
    .MAX_COLS  (MAX_COLS),
    .COST_WIDTH(COST_WIDTH),
    .SUM_WIDTH (SUM_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_cost      (b_cost),
    .q_col       (b_col),
    .q_flags     (b_flags),
    .q_pop       (q_pop),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .min_cost    (min_cost)
  );

endmodule

// File: design/gmcp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gmcp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/gmcp_front.sv
// Front end: configuration registers, cell acceptance and position tracking.
// Tags each accepted cell with its column and row/column edge flags.
// Depends on gmcp_pkg.
module gmcp_front #(
  parameter int MAX_ROWS   = gmcp_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS   = gmcp_pkg::MAX_COLS_DEF,
  parameter int COST_WIDTH = gmcp_pkg::COST_WIDTH_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          cfg_valid,
  output logic                                          cfg_ready,
  input  logic [gmcp_pkg::CFG_INDEX_WIDTH-1:0]          cfg_index,
  input  logic [gmcp_pkg::CFG_DATA_WIDTH-1:0]           cfg_data,
  input  logic                                          cell_valid,
  output logic                                          cell_stall,
  input  logic signed [COST_WIDTH-1:0]                  cell_cost,
  input  logic                                          q_full,
  output logic                                          q_push,
  output logic signed [COST_WIDTH-1:0]                  q_cost,
  output logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] q_col,
  output gmcp_pkg::cell_flags_t                         q_flags
);
  import gmcp_pkg::*;

  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  logic [CW-1:0] col_pos;
  logic [RW-1:0] row_pos;
  logic [CW-1:0] col_last;
  logic [RW-1:0] row_last;
  logic [CW-1:0] col_last_next;
  logic [RW-1:0] row_last_next;
  logic          cfg_we;
  logic          set_rows;
  logic          set_cols;
  logic          col_end;
  logic          row_end;

  assign cfg_ready  = 1'b1;
  assign cfg_we     = cfg_valid && cfg_ready;
  assign cell_stall = q_full;
  assign q_push     = cell_valid && !q_full;
  assign q_cost     = cell_cost;
  assign q_col      = col_pos;

  assign col_end = (col_pos == col_last);
  assign row_end = (row_pos == row_last);

  always_comb begin
    q_flags.first_row = (row_pos == '0);
    q_flags.first_col = (col_pos == '0);
    q_flags.last      = col_end && row_end;
  end

  always_comb begin
    set_rows = 1'b0;
    set_cols = 1'b0;
    unique case (cfg_index)
      REG_ROW_COUNT: set_rows = cfg_we;
      REG_COL_COUNT: set_cols = cfg_we;
      default: ;
    endcase
  end

  // Clamp the count to 1..MAX and hold it as a last index
  always_comb begin
    if (cfg_data == '0) begin
      row_last_next = '0;
      col_last_next = '0;
    end else begin
      if (32'(cfg_data) > MAX_ROWS) begin
        row_last_next = RW'(MAX_ROWS - 1);
      end else begin
        row_last_next = RW'(cfg_data - CFG_DATA_WIDTH'(1));
      end
      if (32'(cfg_data) > MAX_COLS) begin
        col_last_next = CW'(MAX_COLS - 1);
      end else begin
        col_last_next = CW'(cfg_data - CFG_DATA_WIDTH'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_last <= '0;
      col_last <= '0;
      row_pos  <= '0;
      col_pos  <= '0;
    end else if (set_rows || set_cols) begin
      if (set_rows) begin
        row_last <= row_last_next;
      end
      if (set_cols) begin
        col_last <= col_last_next;
      end
      row_pos <= '0;
      col_pos <= '0;
    end else if (q_push) begin
      if (col_end) begin
        col_pos <= '0;
        row_pos <= row_end ? '0 : row_pos + RW'(1);
      end else begin
        col_pos <= col_pos + CW'(1);
      end
    end
  end

endmodule

// File: design/gmcp_queue.sv
// Small register FIFO between the front end and the back end.
// Depends on gmcp_pkg for the default depth.
module gmcp_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = gmcp_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] pop_data
);
  import gmcp_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [NW-1:0]    count;

  assign full      = (count == NW'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + NW'(1);
      end else if (pop && !push) begin
        count <= count - NW'(1);
      end
    end
  end

endmodule

// File: design/gmcp_back.sv
// Back end: row buffer RAM, left/diagonal sums, min-of-three update, result register.
// Depends on gmcp_pkg and gmcp_ram.
module gmcp_back #(
  parameter int MAX_COLS   = gmcp_pkg::MAX_COLS_DEF,
  parameter int COST_WIDTH = gmcp_pkg::COST_WIDTH_DEF,
  parameter int SUM_WIDTH  = 28
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          q_valid,
  input  logic signed [COST_WIDTH-1:0]                  q_cost,
  input  logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] q_col,
  input  gmcp_pkg::cell_flags_t                         q_flags,
  output logic                                          q_pop,
  output logic                                          result_valid,
  input  logic                                          result_stall,
  output logic signed [gmcp_pkg::OUT_WIDTH-1:0]         min_cost
);
  import gmcp_pkg::*;

  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  logic                        b_valid;
  logic signed [COST_WIDTH-1:0] b_cost;
  logic [CW-1:0]               b_col;
  cell_flags_t                 b_flags;
  logic                        b_fire;
  logic                        byp_hit;
  logic signed [SUM_WIDTH-1:0] byp_sum;
  logic signed [SUM_WIDTH-1:0] left_sum;
  logic signed [SUM_WIDTH-1:0] diag_sum;
  logic [SUM_WIDTH-1:0]        ram_rdata;
  logic signed [SUM_WIDTH-1:0] up;
  logic signed [SUM_WIDTH-1:0] cost_ext;
  logic signed [SUM_WIDTH-1:0] min_ul;
  logic signed [SUM_WIDTH-1:0] min_all;
  logic signed [SUM_WIDTH-1:0] base;
  logic signed [SUM_WIDTH-1:0] sum;

  assign b_fire = b_valid && (!b_flags.last || !result_valid || !result_stall);
  assign q_pop  = q_valid && (!b_valid || b_fire);

  gmcp_ram #(
    .WIDTH(SUM_WIDTH),
    .DEPTH(MAX_COLS)
  ) u_row_sums (
    .clk  (clk),
    .we   (b_fire),
    .waddr(b_col),
    .wdata(sum),
    .re   (q_pop),
    .raddr(q_col),
    .rdata(ram_rdata)
  );

  always_comb begin
    up       = byp_hit ? byp_sum : $signed(ram_rdata);
    cost_ext = SUM_WIDTH'(b_cost);
    min_ul   = (up < left_sum) ? up : left_sum;
    min_all  = (min_ul < diag_sum) ? min_ul : diag_sum;
    if (b_flags.first_row) begin
      base = b_flags.first_col ? '0 : left_sum;
    end else begin
      base = b_flags.first_col ? up : min_all;
    end
    sum = base + cost_ext;
  end

  // Hold the request and the forwarded sum for a same-column write
  always_ff @(posedge clk) begin
    if (q_pop) begin
      b_cost  <= q_cost;
      b_col   <= q_col;
      b_flags <= q_flags;
      byp_sum <= sum;
    end
    if (b_fire && b_flags.last) begin
      min_cost <= OUT_WIDTH'(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid      <= 1'b0;
      byp_hit      <= 1'b0;
      result_valid <= 1'b0;
      left_sum     <= '0;
      diag_sum     <= '0;
    end else begin
      if (q_pop) begin
        b_valid <= 1'b1;
        byp_hit <= b_fire && (b_col == q_col);
      end else if (b_fire) begin
        b_valid <= 1'b0;
      end

      if (b_fire) begin
        if (b_flags.last) begin
          left_sum <= '0;
          diag_sum <= '0;
        end else begin
          left_sum <= sum;
          if (!b_flags.first_row) begin
            diag_sum <= up;
          end
        end
      end

      if (b_fire && b_flags.last) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

// File: design/gmcp_checker.sv
// Port-level checker for grid_min_cost_path, attached by bind.
// Depends on gmcp_pkg and grid_min_cost_path_defines.svh.
`include "grid_min_cost_path_defines.svh"

module gmcp_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  cell_valid,
  input logic                                  cell_stall,
  input logic                                  cfg_ready,
  input logic                                  result_valid,
  input logic                                  result_stall,
  input logic signed [gmcp_pkg::OUT_WIDTH-1:0] min_cost
);
  import gmcp_pkg::*;

  `GMCP_ASSERT_NEXT(a_result_held, result_valid && result_stall, result_valid, "result dropped while stalled")
  `GMCP_ASSERT_NEXT(a_result_stable, result_valid && result_stall, $stable(min_cost), "stalled min_cost changed")
  `GMCP_ASSERT_NOW(a_stall_cause, cell_stall, $past(result_valid && result_stall), "cell stall without a blocked result")
  `GMCP_ASSERT_NOW(a_cfg_open, cell_valid || !cell_valid, cfg_ready, "configuration port not ready")

endmodule

bind grid_min_cost_path gmcp_checker u_gmcp_checker (.*);
